// File: design/pouc_pkg.sv
// Shared types, constants and helper functions of the pattern occurrence counter.
package pouc_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam int SYM_W    = 2;
    localparam int PAT_W    = 64;
    localparam int LEN_W    = 6;
    localparam int WGT_W    = 16;
    localparam int NIB_W    = 4;
    localparam int CNT_W    = 32;
    localparam int MIN_W    = 32;
    localparam int CFG_W    = 64;
    localparam int GSUM_W   = 6;
    localparam int WSUM_W   = 9;
    localparam int CAND_W   = CNT_W + 3;
    localparam int LHS_W    = CNT_W + WSUM_W;
    localparam int RHS_W    = MIN_W + LEN_W;
    localparam int GRP_SIZE = 4;

    localparam logic [PAT_W-1:0] PAT_RST = '0;
    localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(1);
    localparam logic [WGT_W-1:0] WGT_RST = 16'h4663;
    localparam logic [MIN_W-1:0] MIN_RST = '0;

    typedef enum logic [1:0] {
        CFG_PATTERN,
        CFG_LENGTH,
        CFG_WEIGHTS,
        CFG_MIN_UTIL
    } cfg_index_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             sequence_end;
        logic             database_end;
    } in_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] sequence_count;
        logic [CNT_W-1:0] total_count;
        logic             is_candidate;
        logic             is_frequent;
        logic             final_result;
    } out_word_t;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic             vld;
        logic [SYM_W-1:0] sym;
    } cell_link_t;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // A finished sequence handed from the matcher to the result pipeline.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] seq_count;
        logic             last;
    } seq_done_t;

    function automatic logic [SYM_W-1:0] pat_sym(input logic [PAT_W-1:0] pat,
                                                 input logic [4:0] idx);
        return pat[{idx, 1'b0} +: SYM_W];
    endfunction

    function automatic logic [NIB_W-1:0] sym_weight(input logic [WGT_W-1:0] wgt,
                                                    input logic [SYM_W-1:0] sym);
        return wgt[{sym, 2'b00} +: NIB_W];
    endfunction

endpackage

// File: design/pouc_cell.sv
// One cell of the window chain: holds one earlier symbol and compares it to its pattern slot.
module pouc_cell #(
    parameter int IDX = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pouc_pkg::cell_ctl_t            ctl,
    input  pouc_pkg::cell_link_t           link_in,
    output pouc_pkg::cell_link_t           link_out,
    input  logic [pouc_pkg::PAT_W-1:0]     pattern,
    input  logic [pouc_pkg::LEN_W-1:0]     len_eff,
    output logic                           mismatch
);
    import pouc_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic [LEN_W-1:0] pos;
    logic             active;

    always_comb
    begin
        vld_next = vld_reg;
        sym_next = sym_reg;
        if (ctl.shift)
        begin
            sym_next = link_in.sym;
            vld_next = link_in.vld && !ctl.clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    // This cell holds the symbol IDX places back, which must equal pattern slot len-1-IDX.
    assign pos      = len_eff - LEN_W'(IDX + 1);
    assign active   = len_eff > LEN_W'(IDX);
    assign mismatch = active && (!vld_reg || (sym_reg != pat_sym(pattern, pos[4:0])));
    assign link_out = '{vld: vld_reg, sym: sym_reg};

endmodule

// File: design/pouc_wsum.sv
// Registered two-level adder tree for the summed utility weight of the pattern.
module pouc_wsum #(
    parameter int MAX_PATTERN = pouc_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic [pouc_pkg::PAT_W-1:0]     pattern,
    input  logic [pouc_pkg::WGT_W-1:0]     weights,
    input  logic [pouc_pkg::LEN_W-1:0]     len_eff,
    output logic [pouc_pkg::WSUM_W-1:0]    wsum
);
    import pouc_pkg::*;

    localparam int NGRP = (MAX_PATTERN + GRP_SIZE - 1) / GRP_SIZE;

    logic [GSUM_W-1:0] grp_reg  [NGRP];
    logic [GSUM_W-1:0] grp_next [NGRP];
    logic [WSUM_W-1:0] wsum_reg;
    logic [WSUM_W-1:0] wsum_next;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if ((g * GRP_SIZE + k < MAX_PATTERN) &&
                    (LEN_W'(g * GRP_SIZE + k) < len_eff))
                begin
                    grp_next[g] = grp_next[g] + GSUM_W'(sym_weight(weights,
                                  pat_sym(pattern, 5'(g * GRP_SIZE + k))));
                end
            end
        end
    end

    always_comb
    begin
        wsum_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            wsum_next = wsum_next + WSUM_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        wsum_reg <= wsum_next;
    end

    assign wsum = wsum_reg;

endmodule

// File: design/pouc_result.sv
// Result pipeline: running total, threshold products and compares, and the output register.
module pouc_result (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pouc_pkg::seq_done_t            done,
    output logic                           take_ok,
    input  logic [pouc_pkg::WSUM_W-1:0]    wsum,
    input  logic [pouc_pkg::MIN_W-1:0]     min_utility,
    input  logic [pouc_pkg::LEN_W-1:0]     len_eff,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pouc_pkg::out_word_t            out_word
);
    import pouc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [CNT_W-1:0] seq1_reg, seq2_reg, seq3_reg, seq4_reg;
    logic             last1_reg, last2_reg, last3_reg, last4_reg;
    logic [CNT_W-1:0] tot2_reg, tot3_reg, tot4_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [CNT_W:0]   tot_sum;
    logic [CNT_W-1:0] tot_sat;
    logic [CAND_W-1:0] cand_next, cand3_reg;
    logic [RHS_W-1:0]  rhs_next, rhs3_reg, rhs4_reg;
    logic [LHS_W-1:0]  lhs_next, lhs4_reg;
    logic              cflag_next, cflag4_reg;
    logic              fflag_next;
    out_word_t         out_reg;
    out_word_t         out_next;

    // A stage can take a new word when it is empty or its word moves on.
    assign rdy5    = !v5_reg || !out_stall;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign take_ok = rdy1;

    assign tot_sum    = {1'b0, total_reg} + {1'b0, seq1_reg};
    assign tot_sat    = tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
    assign total_next = last1_reg ? '0 : tot_sat;

    assign cand_next  = {1'b0, tot2_reg, 2'b00} + {2'b00, tot2_reg, 1'b0};
    assign rhs_next   = min_utility * len_eff;
    assign lhs_next   = tot3_reg * wsum;
    assign cflag_next = cand3_reg >= CAND_W'(min_utility);
    assign fflag_next = lhs4_reg >= LHS_W'(rhs4_reg);

    always_comb
    begin
        out_next.sequence_count = seq4_reg;
        out_next.total_count    = tot4_reg;
        out_next.is_candidate   = last4_reg && cflag4_reg;
        out_next.is_frequent    = last4_reg && fflag_next;
        out_next.final_result   = last4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= done.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy2 && v1_reg)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && done.valid)
        begin
            seq1_reg  <= done.seq_count;
            last1_reg <= done.last;
        end
        if (rdy2 && v1_reg)
        begin
            seq2_reg  <= seq1_reg;
            tot2_reg  <= tot_sat;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            seq3_reg  <= seq2_reg;
            tot3_reg  <= tot2_reg;
            last3_reg <= last2_reg;
            cand3_reg <= cand_next;
            rhs3_reg  <= rhs_next;
        end
        if (rdy4 && v3_reg)
        begin
            seq4_reg   <= seq3_reg;
            tot4_reg   <= tot3_reg;
            last4_reg  <= last3_reg;
            cflag4_reg <= cflag_next;
            lhs4_reg   <= lhs_next;
            rhs4_reg   <= rhs3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_word  = out_reg;

endmodule

// File: design/pattern_occurrence_utility_counter.sv
// Top level: counts occurrences of a configured DNA pattern per sequence and per database.
// Throughput: one symbol word per clock unless the full result pipeline is stalled; the cell
// chain compares a full window against the pattern in the cycle the symbol arrives.
// Results: the word for a sequence is registered through the five-stage total/multiply/compare
// pipeline, starting at the accepting edge of the symbol that ends the sequence.
// Reset: asynchronous, active low; registers return to their reset values, counts to zero.
module pattern_occurrence_utility_counter #(
    parameter int MAX_PATTERN = pouc_pkg::MAX_PATTERN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pouc_pkg::in_word_t          in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pouc_pkg::out_word_t         out_word,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  pouc_pkg::cfg_index_t        cfg_index,
    input  logic [pouc_pkg::CFG_W-1:0]  cfg_data
);
    import pouc_pkg::*;

    // Cell i (from 1) holds the symbol i places back in the current sequence. With a
    // one-symbol pattern there is still one cell, which then never takes part.
    localparam int NCELL = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [WGT_W-1:0] wgt_reg, wgt_next;
    logic [MIN_W-1:0] min_reg, min_next;
    logic [CNT_W-1:0] seq_cnt_reg, seq_cnt_next;

    logic             cfg_we;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_m1;
    logic             take_ok;
    logic             in_take;
    logic             seq_close;
    logic             head_ok;
    logic             hit;
    logic [CNT_W-1:0] seq_new;
    logic [NCELL-1:0] mism;
    logic [WSUM_W-1:0] wsum;
    cell_ctl_t        cell_ctl;
    cell_link_t       head_link;
    cell_link_t       links [NCELL];
    seq_done_t        done;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        pat_next = pat_reg;
        len_next = len_reg;
        wgt_next = wgt_reg;
        min_next = min_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN:  pat_next = cfg_data;
                CFG_LENGTH:   len_next = cfg_data[LEN_W-1:0];
                CFG_WEIGHTS:  wgt_next = cfg_data[WGT_W-1:0];
                CFG_MIN_UTIL: min_next = cfg_data[MIN_W-1:0];
                default:      pat_next = pat_reg;
            endcase
        end
    end

    // A length of zero behaves as one, and one above the chain's reach as its maximum.
    assign len_eff = (len_reg == '0) ? LEN_W'(1) :
                     ((len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg);
    assign len_m1  = len_eff - LEN_W'(1);

    // An input word is taken whenever the result pipeline has room for a finished sequence.
    assign in_stall  = !take_ok;
    assign in_take   = in_valid && take_ok;
    assign seq_close = in_word.sequence_end || in_word.database_end;

    assign cell_ctl  = '{shift: in_take, clear: seq_close};
    assign head_link = '{vld: 1'b1, sym: in_word.symbol};

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            pouc_cell #(
                .IDX (i + 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .link_in  (head_link),
                .link_out (links[i]),
                .pattern  (pat_reg),
                .len_eff  (len_eff),
                .mismatch (mism[i])
            );
        end
        else
        begin : g_next
            pouc_cell #(
                .IDX (i + 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl),
                .link_in  (links[i-1]),
                .link_out (links[i]),
                .pattern  (pat_reg),
                .len_eff  (len_eff),
                .mismatch (mism[i])
            );
        end
    end

    // The arriving symbol closes a window that matches when it equals the last pattern
    // symbol and every active cell agrees; an empty cell means the window is not full yet.
    assign head_ok = in_word.symbol == pat_sym(pat_reg, len_m1[4:0]);
    assign hit     = head_ok && !(|mism);
    assign seq_new = seq_cnt_reg + CNT_W'(hit && (seq_cnt_reg != '1));

    always_comb
    begin
        seq_cnt_next = seq_cnt_reg;
        if (in_take)
        begin
            seq_cnt_next = seq_close ? '0 : seq_new;
        end
    end

    assign done = '{valid: in_take && seq_close, seq_count: seq_new,
                    last: in_word.database_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg     <= PAT_RST;
            len_reg     <= LEN_RST;
            wgt_reg     <= WGT_RST;
            min_reg     <= MIN_RST;
            seq_cnt_reg <= '0;
        end
        else
        begin
            pat_reg     <= pat_next;
            len_reg     <= len_next;
            wgt_reg     <= wgt_next;
            min_reg     <= min_next;
            seq_cnt_reg <= seq_cnt_next;
        end
    end

    // After a write, the weight sum settles through the group and sum registers, before any result needs it.
    pouc_wsum #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_wsum (
        .clk     (clk),
        .pattern (pat_reg),
        .weights (wgt_reg),
        .len_eff (len_eff),
        .wsum    (wsum)
    );

    pouc_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .done        (done),
        .take_ok     (take_ok),
        .wsum        (wsum),
        .min_utility (min_reg),
        .len_eff     (len_eff),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word)
    );

endmodule

// File: design/pouc_checker.sv
// Port-level checker for the pattern occurrence counter, bound to the top level.
module pouc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input pouc_pkg::in_word_t          in_word,
    input logic                        out_valid,
    input logic                        out_stall,
    input pouc_pkg::out_word_t         out_word,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input pouc_pkg::cfg_index_t        cfg_index,
    input logic [pouc_pkg::CFG_W-1:0]  cfg_data
);
    import pouc_pkg::*;

    // A stalled symbol word stays offered and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
        else $error("symbol word changed while stalled");

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // The threshold flags only ever come with the word that closes the database.
    a_flags_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.final_result |-> !out_word.is_candidate && !out_word.is_frequent)
        else $error("threshold flag set on a non-final word");

    // The running total always includes the sequence just reported.
    a_total_ge_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.total_count >= out_word.sequence_count)
        else $error("total count below sequence count");

    // Register writes are never held off and always carry a known index and value.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("configuration write not taken");

endmodule

bind pattern_occurrence_utility_counter pouc_checker u_pouc_checker (.*);

// File: sim/testbench.sv
// Self-checking testbench for the pattern occurrence utility counter.
`timescale 1ns / 1ps

module testbench;
    import pouc_pkg::*;

    // Window depth of the block; lengths above it act as this value.
    localparam int WINDOW = MAX_PATTERN_DEF;

    // Symbol codes as they travel on the symbol field.
    localparam logic [SYM_W-1:0] SYM_A = 2'd0;
    localparam logic [SYM_W-1:0] SYM_C = 2'd1;
    localparam logic [SYM_W-1:0] SYM_G = 2'd2;
    localparam logic [SYM_W-1:0] SYM_T = 2'd3;

    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 145;
    // Quiet cycles allowed with no handshake on any channel: many times
    // the longest legal stall or gap.
    localparam int QUIET_LIMIT = 3000;
    // This margin covers the depth of the result pipeline several times over.
    localparam int SETTLE_CYCLES = 12;

    // The predictor keeps its own copy of the registers and the window,
    // works out the report that each closing symbol causes, and compares
    // the reports coming out of the block against them in order.
    class occurrence_tracker;
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length_code;
        logic [WGT_W-1:0] weights;
        logic [MIN_W-1:0] min_utility;
        logic [SYM_W-1:0] history [WINDOW-1];
        int unsigned      fill;
        logic [CNT_W-1:0] seq_hits;
        logic [CNT_W-1:0] db_hits;
        out_word_t        expected_reports [$];
        int unsigned      errors;
        int unsigned      reports_checked;
        int unsigned      databases_closed;

        function new();
            pattern = PAT_RST;
            length_code = LEN_RST;
            weights = WGT_RST;
            min_utility = MIN_RST;
            foreach (history[k]) history[k] = '0;
            fill = 0;
            seq_hits = '0;
            db_hits = '0;
            errors = 0;
            reports_checked = 0;
            databases_closed = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PATTERN:  pattern = data;
                CFG_LENGTH:   length_code = data[LEN_W-1:0];
                CFG_WEIGHTS:  weights = data[WGT_W-1:0];
                CFG_MIN_UTIL: min_utility = data[MIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Length zero acts as one, anything past the window as the window.
        function int unsigned span();
            if (length_code == 0) return 1;
            if (length_code > WINDOW) return WINDOW;
            return length_code;
        endfunction

        function logic [SYM_W-1:0] pattern_at(int unsigned i);
            return pattern[2*i +: SYM_W];
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void absorb_symbol(in_word_t w);
            int unsigned n;
            int unsigned j;
            bit          hit;
            logic [63:0] sum;
            logic [63:0] wsum;
            out_word_t   r;
            n = span();
            // The newest symbol closes a window when it matches the last
            // pattern symbol and the older ones match going backward.
            hit = (fill + 1 >= n) && (pattern_at(n - 1) == w.symbol);
            for (j = 1; j < n; j++)
                if (pattern_at(n - 1 - j) != history[j - 1]) hit = 0;
            if (hit && seq_hits != '1) seq_hits++;
            for (j = WINDOW - 2; j >= 1; j--) history[j] = history[j - 1];
            history[0] = w.symbol;
            if (fill < WINDOW - 1) fill++;
            if (!w.sequence_end && !w.database_end) return;

            sum = 64'(db_hits) + 64'(seq_hits);
            db_hits = (sum > 64'hFFFF_FFFF) ? '1 : sum[CNT_W-1:0];
            r = '0;
            r.sequence_count = seq_hits;
            r.total_count = db_hits;
            r.final_result = w.database_end;
            if (w.database_end) begin
                wsum = '0;
                for (j = 0; j < n; j++)
                    wsum += 64'(weights[4*int'(pattern_at(j)) +: NIB_W]);
                sum = 64'(db_hits);
                r.is_candidate = (sum * 64'd6 >= 64'(min_utility));
                r.is_frequent = (sum * wsum >= 64'(min_utility) * 64'(n));
                db_hits = '0;
                databases_closed++;
            end
            expected_reports.insert(expected_reports.size(), r);
            fill = 0;
            seq_hits = '0;
        endfunction

        function void flag(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_report(out_word_t got);
            out_word_t want;
            reports_checked++;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: expected no report, got sequence_count %0d total_count %0d",
                             $time, got.sequence_count, got.total_count);
                return;
            end
            want = expected_reports.pop_front();
            if (got.sequence_count !== want.sequence_count)
                flag("sequence_count", want.sequence_count, got.sequence_count);
            if (got.total_count !== want.total_count)
                flag("total_count", want.total_count, got.total_count);
            if (got.is_candidate !== want.is_candidate)
                flag("is_candidate", 32'(want.is_candidate), 32'(got.is_candidate));
            if (got.is_frequent !== want.is_frequent)
                flag("is_frequent", 32'(want.is_frequent), 32'(got.is_frequent));
            if (got.final_result !== want.final_result)
                flag("final_result", 32'(want.final_result), 32'(got.final_result));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_word;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    occurrence_tracker tracker = new();

    int unsigned words_sent = 0;
    int unsigned settings_applied = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    // When set, neither side inserts gaps or stalls.
    bit          steady = 1'b0;

    pattern_occurrence_utility_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // A pattern that repeats a short random period, so that occurrences
    // overlap inside long runs of the same motif.
    function automatic logic [PAT_W-1:0] periodic_pattern();
        logic [PAT_W-1:0] p;
        logic [5:0]       motif;
        int unsigned      period;
        int unsigned      i;
        period = $urandom_range(1, 3);
        motif = 6'($urandom);
        for (i = 0; i < WINDOW; i++) p[2*i +: SYM_W] = motif[2*(i % period) +: SYM_W];
        return p;
    endfunction

    function automatic in_word_t make_word(logic [SYM_W-1:0] sym, logic seq_end, logic db_end);
        in_word_t w;
        w.symbol = sym;
        w.sequence_end = seq_end;
        w.database_end = db_end;
        return w;
    endfunction

    // Report checking and stall generation on the result side. The word is
    // taken at an edge where valid is high and stall was low before it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) tracker.check_report(out_word);
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!steady && $urandom_range(0, 99) < 30) begin
            stall_left <= pick_gap() - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // The watchdog ends the run when no channel moves a word for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("No handshake for %0d cycles, %0d reports still awaited",
                     quiet_cycles, tracker.pending());
            $display("RESULT: ERROR");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one symbol word and holds it until the block takes it. Valid is
    // left high so that a following word goes out back to back; it is only
    // lowered when a gap follows.
    task automatic send_word(input in_word_t w);
        int unsigned gap;
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        tracker.absorb_symbol(w);
        words_sent++;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The sender pauses until every report already owed has come out.
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_register(idx, data);
    endtask

    // Registers are only written once the block is idle: all reports out,
    // plus the pipeline depth so that nothing is still in flight.
    task automatic apply_setting(input logic [CFG_W-1:0] pat, input logic [CFG_W-1:0] len,
                                 input logic [CFG_W-1:0] wgt, input logic [CFG_W-1:0] min);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_PATTERN, pat);
        write_register(CFG_LENGTH, len);
        write_register(CFG_WEIGHTS, wgt);
        write_register(CFG_MIN_UTIL, min);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Upper bits of the narrow registers carry junk that the block must drop.
    task automatic configure_phase(input int ph);
        logic [CFG_W-1:0] pat;
        logic [LEN_W-1:0] len;
        logic [WGT_W-1:0] wgt;
        logic [MIN_W-1:0] min;
        pat = {$urandom, $urandom};
        wgt = 16'($urandom);
        min = $urandom_range(0, 150);
        case (ph)
            0: len = 6'($urandom_range(2, 4));
            1: begin len = 6'd1; min = $urandom_range(0, 100); end
            2: begin len = 6'd32; pat = periodic_pattern(); wgt = 16'hFFFF; min = '1; end
            3: begin len = 6'd0; min = '0; end
            4: begin len = 6'd63; pat = periodic_pattern(); min = $urandom_range(0, 300); end
            5: begin len = 6'($urandom_range(5, 12)); min = $urandom_range(0, 400); end
            6: begin len = 6'($urandom_range(13, 31)); pat = periodic_pattern(); end
            7: begin len = 6'($urandom_range(33, 62)); pat = periodic_pattern(); end
            8: begin len = 6'($urandom_range(2, 6)); wgt = '0; min = $urandom_range(0, 50); end
            default: len = 6'($urandom_range(1, 3));
        endcase
        apply_setting(pat, {$urandom, 26'($urandom), len}, {$urandom, 16'($urandom), wgt},
                      {$urandom, min});
    endtask

    // Builds one sequence out of whole copies of the pattern, cut-off
    // prefixes and random filler, so that most sequences hold real
    // occurrences; a few are pure noise. Some close the database, and some
    // of those flag only the database end.
    task automatic send_sequence();
        logic [SYM_W-1:0] syms [$];
        int unsigned      n;
        int unsigned      cut;
        int unsigned      i;
        bit               close_db;
        bit               drop_seq_end;
        bit               last;
        n = tracker.span();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 24)) syms.insert(syms.size(), SYM_W'($urandom));
        end
        else begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: cut = n;
                    5, 6:          cut = $urandom_range(1, n);
                    default:       cut = 0;
                endcase
                for (i = 0; i < cut; i++) syms.insert(syms.size(), tracker.pattern_at(i));
                if (cut == 0 || $urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 4)) syms.insert(syms.size(), SYM_W'($urandom));
            end
        end
        close_db = ($urandom_range(0, 4) == 0);
        drop_seq_end = close_db && ($urandom_range(0, 3) == 0);
        for (i = 0; i < syms.size(); i++) begin
            last = (i == syms.size() - 1);
            send_word(make_word(syms[i], last && !drop_seq_end, last && close_db));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PATTERN;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: pattern "a" of length one. Two hits in the first
        // sequence, then a database end without a sequence end.
        send_word(make_word(SYM_A, 1'b0, 1'b0));
        send_word(make_word(SYM_C, 1'b0, 1'b0));
        send_word(make_word(SYM_A, 1'b1, 1'b0));
        send_word(make_word(SYM_T, 1'b0, 1'b1));

        // Length zero behaves as one. Heavy weights and a threshold of 20
        // make the pattern frequent while it is not a candidate.
        apply_setting(64'h3, 64'd0, 64'hFFFF, 64'd20);
        send_word(make_word(SYM_T, 1'b0, 1'b0));
        send_word(make_word(SYM_T, 1'b1, 1'b1));

        // Longest length code with all-t pattern and the largest threshold:
        // a short run must not match, and neither flag may rise.
        apply_setting('1, 64'd63, 64'h0, 64'hFFFF_FFFF);
        send_word(make_word(SYM_T, 1'b0, 1'b0));
        send_word(make_word(SYM_T, 1'b0, 1'b0));
        send_word(make_word(SYM_T, 1'b0, 1'b0));
        send_word(make_word(SYM_T, 1'b0, 1'b1));

        // Pattern "cc": overlapping hits count, and a window never reaches
        // across a sequence boundary.
        apply_setting(64'h5, 64'd2, 64'h0010, 64'd0);
        send_word(make_word(SYM_C, 1'b0, 1'b0));
        send_word(make_word(SYM_C, 1'b0, 1'b0));
        send_word(make_word(SYM_C, 1'b1, 1'b0));
        send_word(make_word(SYM_C, 1'b1, 1'b0));
        send_word(make_word(SYM_G, 1'b0, 1'b0));
        send_word(make_word(SYM_C, 1'b0, 1'b0));
        send_word(make_word(SYM_C, 1'b1, 1'b1));

        // Random part: each phase picks new register values, then streams
        // sequences until its share of words has gone out. Two phases run
        // without any gaps or stalls.
        for (int ph = 0; ph < PHASES; ph++) begin
            int unsigned budget;
            int unsigned seq_no;
            configure_phase(ph);
            steady = (ph == 1 || ph == 5);
            budget = words_sent + PHASE_WORDS;
            seq_no = 0;
            while (words_sent < budget) begin
                if ((ph == 2 && seq_no == 3) || $urandom_range(0, 29) == 0) drain_reports();
                send_sequence();
                seq_no++;
            end
        end

        steady = 1'b0;
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d symbol words under %0d register settings;",
                 words_sent, settings_applied);
        $display("checked %0d sequence reports, %0d of them closing a database.",
                 tracker.reports_checked, tracker.databases_closed);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
